/* rtl/msfd_pkg.sv */
// Package for the magic sync frame deframer: phase codes, constants and result type.
package msfd_pkg;

   localparam int unsigned STORE_BYTES  = 2048;
   localparam int unsigned HEADER_BYTES = 12;

   localparam logic [31:0] MAGIC_WORD      = 32'hDEAD_BEEF;
   localparam logic [15:0] MAX_LEN_LIMIT   = 16'(STORE_BYTES - HEADER_BYTES);
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'd2036;

   // header byte positions after the magic word
   localparam logic [3:0] HDR_LEN_LO  = 4'd4;
   localparam logic [3:0] HDR_LEN_HI  = 4'd5;
   localparam logic [3:0] HDR_TYPE_LO = 4'd6;
   localparam logic [3:0] HDR_TYPE_HI = 4'd7;
   localparam logic [3:0] HDR_CRC_B0  = 4'd8;
   localparam logic [3:0] HDR_CRC_B1  = 4'd9;
   localparam logic [3:0] HDR_CRC_B2  = 4'd10;
   localparam logic [3:0] HDR_LAST    = 4'd11;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] frame_type;
      logic [31:0] frame_crc;
      logic        last_of_frame;
      logic        empty_frame;
   } result_type;

endpackage

/* rtl/magic_sync_frame_deframer_unit.sv */
// Magic sync frame deframer: magic word hunt, header capture and payload tagging.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid, req_stall, req_rx_byte            | in
//  rsp     | rsp_valid, rsp_stall, rsp_payload_byte, ...  | out
//  csr     | csr_write_enable, csr_write_data             | in
//
// One byte per cycle while req_stall is low; a taken byte's result, if it has one,
// follows it through the input register into the result register or skid register.
// Synchronous active-high reset returns to hunting with max_payload at 2036.
// A skid register behind the result register absorbs one result under rsp_stall;
// req_stall rises only while the skid register is occupied.
module magic_sync_frame_deframer_unit
   import msfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_frame_type,
   output logic [31:0] rsp_frame_crc,
   output logic        rsp_last_of_frame,
   output logic        rsp_empty_frame,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0] max_payload_ff;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] recent_ff, recent_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] type_ff, type_in;
   logic [31:0] crc_ff, crc_in;

   logic        res_valid;
   result_type  res;

   logic        out_valid_ff, skid_valid_ff;
   result_type  out_ff, skid_ff;

   logic        proc;
   logic        out_take;
   logic        too_long;

   assign req_stall = skid_valid_ff;
   assign proc      = in_valid_ff && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign too_long  = (length_ff > MAX_LEN_LIMIT) || (length_ff > max_payload_ff);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      recent_in  = recent_ff;
      hdr_idx_in = hdr_idx_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      type_in    = type_ff;
      crc_in     = crc_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            case (hdr_idx_ff)
               HDR_LEN_LO:  length_in[7:0]  = in_byte_ff;
               HDR_LEN_HI:  length_in[15:8] = in_byte_ff;
               HDR_TYPE_LO: type_in[7:0]    = in_byte_ff;
               HDR_TYPE_HI: type_in[15:8]   = in_byte_ff;
               HDR_CRC_B0:  crc_in[7:0]     = in_byte_ff;
               HDR_CRC_B1:  crc_in[15:8]    = in_byte_ff;
               HDR_CRC_B2:  crc_in[23:16]   = in_byte_ff;
               default:     crc_in[31:24]   = in_byte_ff;
            endcase
            if (hdr_idx_ff != HDR_LAST) begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
            end else begin
               hdr_idx_in = '0;
               if (too_long || (length_ff == '0)) begin
                  phase_in = PH_HUNT;
               end else begin
                  left_in  = length_ff;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (left_ff <= 16'd1) begin
               left_in  = '0;
               phase_in = PH_HUNT;
            end else begin
               left_in = left_ff - 16'd1;
            end
         end
         default: begin
            recent_in = {in_byte_ff, recent_ff[31:8]};
            if (recent_in == MAGIC_WORD) begin
               recent_in  = '0;
               hdr_idx_in = HDR_LEN_LO;
               length_in  = '0;
               type_in    = '0;
               crc_in     = '0;
               phase_in   = PH_HEADER;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // result of the byte in the input register
   always_comb begin
      res_valid         = 1'b0;
      res.payload_byte  = in_byte_ff;
      res.frame_type    = type_ff;
      res.frame_crc     = crc_in;
      res.last_of_frame = 1'b0;
      res.empty_frame   = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            if ((hdr_idx_ff == HDR_LAST) && !too_long && (length_ff == '0)) begin
               res_valid         = 1'b1;
               res.payload_byte  = '0;
               res.last_of_frame = 1'b1;
               res.empty_frame   = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            res_valid         = 1'b1;
            res.last_of_frame = (left_ff <= 16'd1);
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else if (csr_write_enable) begin
         max_payload_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         in_byte_ff <= req_rx_byte;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!skid_valid_ff) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         recent_ff  <= '0;
         hdr_idx_ff <= '0;
         length_ff  <= '0;
         left_ff    <= '0;
         type_ff    <= '0;
         crc_ff     <= '0;
      end else if (proc) begin
         phase_ff   <= phase_in;
         recent_ff  <= recent_in;
         hdr_idx_ff <= hdr_idx_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         type_ff    <= type_in;
         crc_ff     <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (proc && res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_frame_type    = out_ff.frame_type;
   assign rsp_frame_crc     = out_ff.frame_crc;
   assign rsp_last_of_frame = out_ff.last_of_frame;
   assign rsp_empty_frame   = out_ff.empty_frame;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a transaction while result register is empty");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != '0))
      else $error("payload phase with no bytes left");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> ((hdr_idx_ff >= HDR_LEN_LO) && (hdr_idx_ff <= HDR_LAST)))
      else $error("header index out of range");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.empty_frame) |->
         (out_ff.last_of_frame && (out_ff.payload_byte == '0)))
      else $error("empty frame result not marked last or carries data");

endmodule
